// File: rtl/core/smac_pkg.sv
// ----------------------------------------------------------------------------
// smac_pkg: shared types and constants
// Request codes, status codes and the front-to-back command record.
// ----------------------------------------------------------------------------
package smac_pkg;

  localparam int ShadowDepth  = 4096;
  localparam int ShadowAw     = $clog2(ShadowDepth);
  localparam int TableDepth   = 64;
  localparam int TableAw      = $clog2(TableDepth);
  localparam int RedzoneBytes = 32;
  localparam int RzGranules   = RedzoneBytes / 8;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_POISON = 3'd1;
  localparam logic [2:0] ST_DOUBLE = 3'd2;
  localparam logic [2:0] ST_INVAL  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  localparam logic [7:0] POISON_BYTE = 8'hFA;

  // One command for the back end: a status and up to three granule walks.
  // Walk 0 and 1 are redzone fills, walk 2 is the region fill or the check.
  typedef struct packed {
    logic [2:0]  status;
    logic        count_err;
    logic        do_rz;
    logic [17:0] rz0_first;  // signed granule index
    logic [17:0] rz1_first;
    logic        do_main;
    logic        main_check;
    logic [7:0]  main_value;
    logic [17:0] main_first;
    logic [12:0] main_count;
  } smac_cmd_t;

endpackage

// File: rtl/core/smac_ram.sv
// ----------------------------------------------------------------------------
// smac_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module smac_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/core/smac_front.sv
// ----------------------------------------------------------------------------
// smac_front: request classifier
// Accepts requests, searches the region table for frees, records
// allocations, and hands one command per request to the queue.
// ----------------------------------------------------------------------------
module smac_front import smac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  mode,
  input  logic [15:0] address,
  input  logic [11:0] size,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output smac_cmd_t   cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]   state;
  logic [1:0]   r_mode;
  logic [15:0]  r_addr;
  logic [11:0]  r_size;
  logic [TableAw:0] count;
  logic [TableAw:0] idx;
  logic         hit_freed;
  logic [11:0]  hit_size;
  logic         accept;
  logic         alloc_ok;
  logic         match;
  logic         full_at_accept;

  logic                tbl_we;
  logic [TableAw-1:0]  tbl_addr;
  logic [28:0]         tbl_wdata, tbl_rdata;

  smac_ram #(.Width(29), .Depth(TableDepth)) u_tbl (
    .clk(clk), .we(tbl_we), .addr(tbl_addr), .wdata(tbl_wdata), .rdata(tbl_rdata)
  );

  assign ready = (state == S_IDLE);
  assign cmd_valid = (state == S_OUT);

  assign accept = valid && ready;
  assign alloc_ok = accept && mode == MODE_ALLOC && count != (TableAw+1)'(TableDepth);
  // An entry holds {freed, address, size}; a free hit sets the freed flag in place.
  assign match = (state == S_SRCH) && (tbl_rdata[27:12] == r_addr);
  assign tbl_we = alloc_ok || (match && !tbl_rdata[28]);
  assign tbl_addr = accept ? count[TableAw-1:0] : idx[TableAw-1:0];
  assign tbl_wdata = accept ? {1'b0, address, size} : {1'b1, tbl_rdata[27:0]};

  logic [17:0] a_gr, lead, end_gr;
  logic [16:0] a_end;
  always_comb begin
    a_gr  = {5'd0, r_addr[15:3]};
    a_end = {1'b0, r_addr} + {5'd0, r_size};
    end_gr = {4'd0, a_end[16:3]};
    // Floor of (address - redzone) / 8 as a signed granule.
    lead = 18'({2'b00, r_addr} - 18'(RedzoneBytes)) >>> 3;
    lead = {{3{lead[14]}}, lead[14:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: if (accept) begin
          r_mode <= mode; r_addr <= address; r_size <= size;
          if (alloc_ok) count <= count + 1'b1;
          state <= (mode == MODE_FREE && address != 16'd0 && count != '0) ? S_WAIT : S_OUT;
          hit_freed <= 1'b0;
          hit_size <= '0;
          idx <= '0;
        end
        S_WAIT: state <= S_SRCH;
        S_SRCH: begin
          // tbl_rdata holds entry idx.
          if (match) begin
            hit_freed <= tbl_rdata[28];
            hit_size <= tbl_rdata[11:0];
            idx <= count + 1'b1;  // marks a hit
            state <= S_OUT;
          end else if (idx + 1'b1 == count) begin
            idx <= '0;
            state <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
            state <= S_WAIT;
          end
        end
        S_OUT: if (cmd_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Build the command from the registered request and search result.
  logic hit;
  always_comb begin
    hit = (idx != '0);
    cmd = '0;
    cmd.rz0_first  = lead;
    cmd.rz1_first  = end_gr;
    cmd.main_first = a_gr;
    case (r_mode)
      MODE_ALLOC: begin
        cmd.status = ST_OK;
        cmd.do_rz = 1'b1;
        cmd.do_main = 1'b1;
        cmd.main_value = 8'h00;
        cmd.main_count = {4'd0, r_size[11:3]};
      end
      MODE_FREE: begin
        if (r_addr == 16'd0) cmd.status = ST_OK;
        else if (!hit) begin cmd.status = ST_INVAL; cmd.count_err = 1'b1; end
        else if (hit_freed) begin cmd.status = ST_DOUBLE; cmd.count_err = 1'b1; end
        else begin
          cmd.do_main = 1'b1;
          cmd.main_value = POISON_BYTE;
          cmd.main_count = {4'd0, hit_size[11:3]};
        end
      end
      MODE_CHECK: begin
        cmd.do_main = 1'b1;
        cmd.main_check = 1'b1;
        cmd.main_count = {4'd0, r_size[11:3]} + 13'd1;
      end
      default: cmd.status = ST_OK;
    endcase
    if (r_mode == MODE_ALLOC && full_at_accept) begin
      cmd = '0;
      cmd.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) full_at_accept <= (count == (TableAw+1)'(TableDepth));
  end
endmodule

// File: rtl/core/smac_queue.sv
// ----------------------------------------------------------------------------
// smac_queue: two-entry command queue
// Decouples the classifier from the shadow walker.
// ----------------------------------------------------------------------------
module smac_queue import smac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  smac_cmd_t in_cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output smac_cmd_t out_cmd
);
  smac_cmd_t slot [2];
  logic      wp, rp;
  logic [1:0] fill;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_cmd   = slot[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slot[wp] <= in_cmd;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= '0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      fill <= fill + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end
endmodule

// File: rtl/core/smac_back.sv
// ----------------------------------------------------------------------------
// smac_back: shadow walker
// Runs the granule fills and checks of one command against the shadow
// memory, keeps the error count and holds the result for the consumer.
// ----------------------------------------------------------------------------
module smac_back import smac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  smac_cmd_t   cmd,
  output logic        valid,
  input  logic        ready,
  output logic [2:0]  status,
  output logic [15:0] error_total
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RZ0   = 3'd2;
  localparam logic [2:0] S_RZ1   = 3'd3;
  localparam logic [2:0] S_MAIN  = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state;
  smac_cmd_t   c;
  logic [17:0] g;
  logic [12:0] left;
  logic        pend;   // a read is in flight in check mode
  logic [ShadowAw:0] clr;

  logic                sh_we;
  logic [ShadowAw-1:0] sh_addr;
  logic [7:0]          sh_wdata, sh_rdata;
  logic                in_rng;

  smac_ram #(.Width(8), .Depth(ShadowDepth)) u_shadow (
    .clk(clk), .we(sh_we), .addr(sh_addr), .wdata(sh_wdata), .rdata(sh_rdata)
  );

  assign in_rng = !g[17] && g < 18'(ShadowDepth);
  assign cmd_ready = (state == S_IDLE) && !valid;

  always_comb begin
    sh_we = 1'b0; sh_wdata = POISON_BYTE;
    sh_addr = g[ShadowAw-1:0];
    case (state)
      S_CLEAR: begin sh_we = 1'b1; sh_wdata = 8'h00; sh_addr = clr[ShadowAw-1:0]; end
      S_RZ0, S_RZ1: sh_we = in_rng && left != '0;
      S_MAIN: begin sh_we = in_rng && left != '0; sh_wdata = c.main_value; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr <= '0; valid <= 1'b0; error_total <= '0; pend <= 1'b0;
    end else begin
      if (valid && ready) valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (ShadowAw+1)'(ShadowDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: if (cmd_valid && cmd_ready) begin
          c <= cmd;
          status <= cmd.status;
          if (cmd.do_rz) begin
            g <= cmd.rz0_first; left <= 13'(RzGranules); state <= S_RZ0;
          end else if (cmd.do_main) begin
            g <= cmd.main_first; left <= cmd.main_count; pend <= 1'b0;
            state <= cmd.main_check ? S_CHK : S_MAIN;
          end else state <= S_DONE;
        end
        S_RZ0: if (left == '0) begin
          g <= c.rz1_first; left <= 13'(RzGranules); state <= S_RZ1;
        end else begin g <= g + 1'b1; left <= left - 1'b1; end
        S_RZ1: if (left == '0) begin
          g <= c.main_first; left <= c.main_count; state <= S_MAIN;
        end else begin g <= g + 1'b1; left <= left - 1'b1; end
        S_MAIN: if (left == '0) state <= S_DONE;
          else begin g <= g + 1'b1; left <= left - 1'b1; end
        S_CHK: begin
          // Granules past the end of the store read as clean.
          if (pend && sh_rdata != 8'h00) begin
            status <= ST_POISON; c.count_err <= 1'b1; state <= S_DONE;
          end else if (left == '0) begin
            state <= S_DONE;
          end else begin
            pend <= in_rng; g <= g + 1'b1; left <= left - 1'b1;
          end
        end
        S_DONE: begin
          if (c.count_err && error_total != 16'hFFFF) error_total <= error_total + 1'b1;
          valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/shadow_memory_access_checker.sv
// ----------------------------------------------------------------------------
// shadow_memory_access_checker: shadow-memory redzone checker
// Allocation, free and access-check requests against a granule shadow store.
// ----------------------------------------------------------------------------
// Channel  Signals                      Direction
// request  valid, ready, mode/address/size   in
// result   out_valid, out_ready, status/error_total   out
//
// A free searches the region table one entry at a time, through a wait and
// a search state per entry. The shadow walker then fills two redzones of
// four granules and the region for an allocation, poisons the region for a
// free, and reads up to size/8 + 1 granules for a check.
// After reset a clearing pass zeroes all 4096 shadow entries; the
// front still accepts requests, which queue until the pass ends.
// Either side may stall; the two-entry queue lets them run independently.
module shadow_memory_access_checker import smac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  mode,
  input  logic [15:0] address,
  input  logic [11:0] size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] error_total
);
  smac_cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  smac_front u_front (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .mode(mode),
    .address(address), .size(size), .cmd_valid(f_valid), .cmd_ready(f_ready),
    .cmd(f_cmd)
  );

  smac_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  smac_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .valid(out_valid), .ready(out_ready), .status(status),
    .error_total(error_total)
  );

  // The error count never moves except when a result is shown.
  a_err_step: assert property (@(posedge clk) disable iff (rst)
    !$rose(out_valid) && !out_valid |=> error_total == $past(error_total) || $rose(out_valid))
    else $error("error count changed without a result");

  a_err_sat: assert property (@(posedge clk) disable iff (rst)
    error_total == 16'hFFFF |=> error_total == 16'hFFFF)
    else $error("error count wrapped");

  a_status_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL)
    else $error("status code out of range");
endmodule
